// ===== src/utility_connection_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Connection allocator assertion macros
// Shorthands for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UTILITY_CONNECTION_ALLOCATOR_TOP_DEFINES_SVH
`define UTILITY_CONNECTION_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UCA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define UCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/uca_pkg.sv =====
// ----------------------------------------------------------------------------
// Connection allocator package
// Word types, field widths and fixed-point constants shared by the design.
// ----------------------------------------------------------------------------
package uca_pkg;

    localparam int SIZE_W     = 40;
    localparam int RATE_W     = 32;
    localparam int WAIT_W     = 32;
    localparam int DL_W       = 32;
    localparam int SLOT_W     = 5;
    localparam int LIMIT_W    = 7;
    localparam int OUT_IDX_W  = 3;
    localparam int RESP_W     = 48;
    localparam int UR_W       = 49;
    localparam int NUM_W      = 48;
    localparam int DEN_W      = 37;
    localparam int UTIL_W     = 16;
    localparam int GL_W       = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 2'd1;

    localparam logic [SLOT_W-1:0]  FREE_SLOTS_RST = 5'd16;
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = 7'd16;

    // Q8.8 utility points
    localparam logic [UTIL_W-1:0] UTIL_FULL = 16'd25600;
    localparam logic [UTIL_W-1:0] UTIL_BASE = 16'd26880;
    localparam logic [UTIL_W-1:0] SLOPE_HI  = 16'd12800;
    localparam logic [UTIL_W-1:0] SLOPE_LO  = 16'd40960;

    localparam logic signed [GL_W-1:0] GAIN_NONE = 18'sh20000;
    localparam logic signed [GL_W-1:0] LOSS_NONE = 18'sh1FFFF;

    localparam logic [RESP_W-1:0] TIME_CAP = 48'h8000_0000_0000;

    typedef struct packed {
        logic [SIZE_W-1:0] job_size;
        logic [RATE_W-1:0] link_rate;
        logic [WAIT_W-1:0] job_wait;
        logic [DL_W-1:0]   deadline;
        logic              last_job;
    } uca_in_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] job_index;
        logic [SLOT_W-1:0]    connections;
        logic                 last_result;
    } uca_out_t;

    typedef struct packed {
        logic [SIZE_W-1:0] job_size;
        logic [RATE_W-1:0] link_rate;
        logic [WAIT_W-1:0] job_wait;
        logic [DL_W-1:0]   deadline;
    } uca_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } uca_div_stat_t;

endpackage

// ===== src/utility_connection_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Utility-driven connection allocator
// Loads a window of jobs and shares free connection slots by marginal utility.
// ----------------------------------------------------------------------------
// Each input word loads one job (size, link rate, time waited, deadline) into
// the job memory. The word that carries last_job starts the allocation, and
// no further word is taken until every result of the window has gone out:
// one result word per loaded job, in load order, with last_result on the
// final one. The allocation runs through the shared radix-2 divider: every
// table entry costs at most one transfer-time division and at most one
// utility division. The steps are an even spread of the slots, the table
// build for each job and connection count, the zero-connection column, the
// marginal moves with a rescan of the table memory for each, and the results.
// Jobs beyond JOB_WINDOW are dropped. Configuration words are taken at any
// time but must only be sent while the block is idle.
`include "utility_connection_allocator_top_defines.svh"

module utility_connection_allocator_top
    import uca_pkg::*;
#(
    parameter int JOB_WINDOW      = 8,
    parameter int MAX_CONNECTIONS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  uca_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output uca_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int JW     = (JOB_WINDOW > 1) ? $clog2(JOB_WINDOW) : 1;
    localparam int CNTW   = $clog2(JOB_WINDOW + 1);
    localparam int COLS   = MAX_CONNECTIONS + 1;
    localparam int TDEPTH = JOB_WINDOW * COLS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int SCAP   = (MAX_CONNECTIONS < 31) ? MAX_CONNECTIONS : 31;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SPREAD, ST_JRD, ST_JLD, ST_MUL, ST_TDIV, ST_TWAIT, ST_RESP,
        ST_UCMP, ST_UMUL, ST_UDIV, ST_UWAIT, ST_UWR, ST_ZRD, ST_ZLD,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_MDEC, ST_OLD, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [SLOT_W-1:0]  free_slots_reg;
    logic [LIMIT_W-1:0] slot_limit_reg;

    // window control
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   n_reg;
    logic [JW-1:0]     idx_reg;
    logic [SLOT_W-1:0] c_reg;
    logic [SLOT_W-1:0] slots_reg;
    logic              zcol_reg;

    logic [SLOT_W-1:0] conn_reg [JOB_WINDOW];
    logic [RESP_W-1:0] lr_reg   [JOB_WINDOW];

    // per-job datapath
    logic [SIZE_W-1:0] jsize_reg;
    logic [RATE_W-1:0] jrate_reg;
    logic [WAIT_W-1:0] jwait_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [RESP_W-1:0] t_reg;
    logic [UR_W-1:0]   ur_reg;
    logic [DL_W-1:0]   ud_reg;
    logic [NUM_W-1:0]  p_reg;
    logic [UTIL_W-1:0] u_reg;
    logic              hi_kind_reg;

    // running best/runner-up picks
    logic [JW-1:0]     m0_reg, m1_reg;
    logic [RESP_W-1:0] rm0_reg, rm1_reg;
    logic [JW-1:0]     a0_reg, a1_reg, b0_reg, b1_reg;
    logic signed [GL_W-1:0] ga0_reg, ga1_reg, lb0_reg, lb1_reg;
    logic [UTIL_W-1:0] lo_reg, mid_reg;

    logic     m_valid_reg;
    uca_out_t m_data_reg;

    // memories
    uca_job_t          pmem [JOB_WINDOW];
    uca_job_t          pq_reg;
    logic [UTIL_W-1:0] tmem [TDEPTH];
    logic [UTIL_W-1:0] tq_reg;

    // divider
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    uca_div_stat_t     div_stat;
    logic [NUM_W-1:0]  div_quo;

    logic              s_accept;
    logic              win_full;
    logic              pmem_we;
    logic [SLOT_W-1:0] slots_calc;
    logic [SLOT_W-1:0] c_max;
    logic              idx_last;
    logic [SLOT_W-1:0] k;
    logic [RESP_W-1:0] lr_sel;
    logic [RESP_W-1:0] resp;
    logic              tmem_we;
    logic [SLOT_W-1:0] wcol;
    logic [SLOT_W-1:0] rcol;
    logic [TAW-1:0]    tw_addr;
    logic [TAW-1:0]    tr_addr;
    logic [UR_W+4:0]   r20;
    logic              le20, le2, le1;
    logic signed [GL_W-1:0] g_calc, l_calc;
    logic signed [GL_W:0]   d0, i1, i2;
    logic              found;
    logic [JW-1:0]     to_idx, from_idx;
    logic              mv;

    uca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign s_accept   = s_valid && s_ready;
    assign win_full   = (count_reg == CNTW'(JOB_WINDOW));
    assign pmem_we    = s_accept && !win_full;
    assign slots_calc = (free_slots_reg > SLOT_W'(SCAP)) ? SLOT_W'(SCAP) : free_slots_reg;
    assign c_max      = (slots_reg == '0) ? SLOT_W'(1) : slots_reg;
    assign idx_last   = ((CNTW'(idx_reg) + CNTW'(1)) == n_reg);
    assign k          = conn_reg[idx_reg];
    assign lr_sel     = lr_reg[idx_reg];
    assign resp       = RESP_W'(jwait_reg) + t_reg;

    // table addressing: row per job, column per connection count
    assign tmem_we = (state_reg == ST_UWR);
    assign wcol    = zcol_reg ? '0 : c_reg;
    assign tw_addr = TAW'(int'(idx_reg) * COLS) + TAW'(wcol);

    always_comb begin
        unique case (state_reg)
            ST_M0:   rcol = (k == '0) ? k : k - SLOT_W'(1);
            ST_M2:   rcol = (k >= slots_reg) ? k : k + SLOT_W'(1);
            default: rcol = k;
        endcase
    end
    assign tr_addr = TAW'(int'(idx_reg) * COLS) + TAW'(rcol);

    // divider operand select: transfer time or utility slope
    assign div_start = ((state_reg == ST_TDIV) && (den_reg != '0)) || (state_reg == ST_UDIV);
    assign div_num   = (state_reg == ST_UDIV) ? p_reg : num_reg;
    assign div_den   = (state_reg == ST_UDIV) ? DEN_W'(ud_reg) : den_reg;

    // deadline bands: 20r, 2r and r against D
    assign r20  = {1'b0, ur_reg, 4'b0} + {3'b0, ur_reg, 2'b0};
    assign le20 = r20 <= (UR_W+5)'(ud_reg);
    assign le2  = {ur_reg, 1'b0} <= (UR_W+1)'(ud_reg);
    assign le1  = ur_reg <= UR_W'(ud_reg);

    // marginal gain and loss of the job under scan
    assign g_calc = (k >= slots_reg) ? GAIN_NONE
                  : $signed({2'b0, tq_reg}) - $signed({2'b0, mid_reg});
    assign l_calc = (k == '0) ? LOSS_NONE
                  : $signed({2'b0, mid_reg}) - $signed({2'b0, lo_reg});

    assign d0 = $signed({ga0_reg[GL_W-1], ga0_reg}) - $signed({lb0_reg[GL_W-1], lb0_reg});
    assign i1 = $signed({ga0_reg[GL_W-1], ga0_reg}) - $signed({lb1_reg[GL_W-1], lb1_reg});
    assign i2 = $signed({ga1_reg[GL_W-1], ga1_reg}) - $signed({lb0_reg[GL_W-1], lb0_reg});

    // move choice: best pair, or runner-up pairings when both picks collide
    always_comb begin
        found    = 1'b0;
        to_idx   = a0_reg;
        from_idx = b0_reg;
        if (a0_reg != b0_reg) begin
            found = (d0 > 0);
        end else if ((i1 >= i2) && (i1 > 0)) begin
            found    = 1'b1;
            from_idx = b1_reg;
        end else if ((i2 > i1) && (i2 > 0)) begin
            found  = 1'b1;
            to_idx = a1_reg;
        end
    end
    assign mv = found && (to_idx != from_idx);

    // job memory
    always_ff @(posedge aclk) begin
        if (pmem_we) begin
            pmem[count_reg[JW-1:0]] <= '{job_size:  s_data.job_size,
                                          link_rate: s_data.link_rate,
                                          job_wait:  s_data.job_wait,
                                          deadline:  s_data.deadline};
        end
        pq_reg <= pmem[idx_reg];
    end

    // utility table memory
    always_ff @(posedge aclk) begin
        if (tmem_we) begin
            tmem[tw_addr] <= u_reg;
        end
        tq_reg <= tmem[tr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            free_slots_reg <= FREE_SLOTS_RST;
            slot_limit_reg <= SLOT_LIMIT_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FREE_SLOTS: free_slots_reg <= cfg_data[SLOT_W-1:0];
                    CFG_SLOT_LIMIT: slot_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_data.last_job) begin
                            n_reg     <= win_full ? count_reg : count_reg + CNTW'(1);
                            count_reg <= '0;
                            slots_reg <= slots_calc;
                            c_reg     <= '0;
                            idx_reg   <= '0;
                            for (int j = 0; j < JOB_WINDOW; j++) begin
                                conn_reg[j] <= '0;
                            end
                            state_reg <= ST_SPREAD;
                        end else if (!win_full) begin
                            count_reg <= count_reg + CNTW'(1);
                        end
                    end
                end

                // deal slots round robin: earlier jobs take the remainder
                ST_SPREAD: begin
                    if (c_reg == slots_reg) begin
                        idx_reg   <= '0;
                        zcol_reg  <= 1'b0;
                        state_reg <= ST_JRD;
                    end else begin
                        for (int j = 0; j < JOB_WINDOW; j++) begin
                            if (JW'(j) == idx_reg) begin
                                conn_reg[j] <= conn_reg[j] + SLOT_W'(1);
                            end
                        end
                        c_reg   <= c_reg + SLOT_W'(1);
                        idx_reg <= idx_last ? '0 : idx_reg + JW'(1);
                    end
                end

                ST_JRD: state_reg <= ST_JLD;

                ST_JLD: begin
                    jsize_reg <= pq_reg.job_size;
                    jrate_reg <= pq_reg.link_rate;
                    jwait_reg <= pq_reg.job_wait;
                    ud_reg    <= pq_reg.deadline;
                    c_reg     <= SLOT_W'(1);
                    state_reg <= ST_MUL;
                end

                ST_MUL: begin
                    num_reg   <= NUM_W'(jsize_reg) * NUM_W'(slot_limit_reg);
                    den_reg   <= DEN_W'(c_reg) * DEN_W'(jrate_reg);
                    state_reg <= ST_TDIV;
                end

                ST_TDIV: begin
                    if (den_reg == '0) begin
                        t_reg     <= TIME_CAP;
                        state_reg <= ST_RESP;
                    end else begin
                        state_reg <= ST_TWAIT;
                    end
                end

                ST_TWAIT: begin
                    if (div_stat.done) begin
                        t_reg     <= div_quo;
                        state_reg <= ST_RESP;
                    end
                end

                ST_RESP: begin
                    ur_reg <= UR_W'(resp);
                    if (c_reg == c_max) begin
                        lr_reg[idx_reg] <= resp;
                        // track the two least responses in load order
                        if (idx_reg == '0) begin
                            m0_reg  <= idx_reg;
                            rm0_reg <= resp;
                            m1_reg  <= idx_reg;
                            rm1_reg <= resp;
                        end else if (idx_reg == JW'(1)) begin
                            if (rm0_reg > resp) begin
                                m0_reg  <= idx_reg;
                                rm0_reg <= resp;
                                m1_reg  <= m0_reg;
                                rm1_reg <= rm0_reg;
                            end else begin
                                m1_reg  <= idx_reg;
                                rm1_reg <= resp;
                            end
                        end else if (rm0_reg > resp) begin
                            m0_reg  <= idx_reg;
                            rm0_reg <= resp;
                            m1_reg  <= m0_reg;
                            rm1_reg <= rm0_reg;
                        end else if (rm1_reg > resp) begin
                            m1_reg  <= idx_reg;
                            rm1_reg <= resp;
                        end
                    end
                    if (slots_reg != '0) begin
                        state_reg <= ST_UCMP;
                    end else if (idx_last) begin
                        zcol_reg  <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= ST_ZRD;
                    end else begin
                        idx_reg   <= idx_reg + JW'(1);
                        state_reg <= ST_JRD;
                    end
                end

                ST_UCMP: begin
                    hi_kind_reg <= le2;
                    if (le20) begin
                        u_reg     <= UTIL_FULL;
                        state_reg <= ST_UWR;
                    end else if (le1) begin
                        state_reg <= ST_UMUL;
                    end else begin
                        u_reg     <= '0;
                        state_reg <= ST_UWR;
                    end
                end

                ST_UMUL: begin
                    if (hi_kind_reg) begin
                        p_reg <= NUM_W'(SLOPE_HI) * NUM_W'(ur_reg[DL_W-1:0]);
                    end else begin
                        p_reg <= NUM_W'(SLOPE_LO) * NUM_W'(ud_reg - ur_reg[DL_W-1:0]);
                    end
                    state_reg <= ST_UDIV;
                end

                ST_UDIV: state_reg <= ST_UWAIT;

                ST_UWAIT: begin
                    if (div_stat.done) begin
                        u_reg     <= hi_kind_reg ? UTIL_BASE - div_quo[UTIL_W-1:0]
                                                 : div_quo[UTIL_W-1:0];
                        state_reg <= ST_UWR;
                    end
                end

                ST_UWR: begin
                    if (zcol_reg) begin
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= ST_M0;
                        end else begin
                            idx_reg   <= idx_reg + JW'(1);
                            state_reg <= ST_ZRD;
                        end
                    end else if (c_reg != c_max) begin
                        c_reg     <= c_reg + SLOT_W'(1);
                        state_reg <= ST_MUL;
                    end else if (idx_last) begin
                        zcol_reg  <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= ST_ZRD;
                    end else begin
                        idx_reg   <= idx_reg + JW'(1);
                        state_reg <= ST_JRD;
                    end
                end

                ST_ZRD: state_reg <= ST_ZLD;

                // zero column: wait behind the fastest other job
                ST_ZLD: begin
                    ud_reg <= pq_reg.deadline;
                    if (n_reg == CNTW'(1)) begin
                        u_reg     <= '0;
                        state_reg <= ST_UWR;
                    end else begin
                        ur_reg    <= UR_W'(lr_sel)
                                   + UR_W'((idx_reg != m0_reg) ? rm0_reg : rm1_reg);
                        state_reg <= ST_UCMP;
                    end
                end

                ST_M0: state_reg <= ST_M1;

                ST_M1: begin
                    lo_reg    <= tq_reg;
                    state_reg <= ST_M2;
                end

                ST_M2: begin
                    mid_reg   <= tq_reg;
                    state_reg <= ST_M3;
                end

                ST_M3: begin
                    if (idx_reg == '0) begin
                        a0_reg  <= idx_reg;
                        ga0_reg <= g_calc;
                        a1_reg  <= idx_reg;
                        ga1_reg <= g_calc;
                        b0_reg  <= idx_reg;
                        lb0_reg <= l_calc;
                        b1_reg  <= idx_reg;
                        lb1_reg <= l_calc;
                    end else begin
                        if (ga0_reg < g_calc) begin
                            a0_reg  <= idx_reg;
                            ga0_reg <= g_calc;
                            a1_reg  <= a0_reg;
                            ga1_reg <= ga0_reg;
                        end else if ((idx_reg == JW'(1)) || (ga1_reg < g_calc)) begin
                            a1_reg  <= idx_reg;
                            ga1_reg <= g_calc;
                        end
                        if (lb0_reg > l_calc) begin
                            b0_reg  <= idx_reg;
                            lb0_reg <= l_calc;
                            b1_reg  <= b0_reg;
                            lb1_reg <= lb0_reg;
                        end else if ((idx_reg == JW'(1)) || (lb1_reg > l_calc)) begin
                            b1_reg  <= idx_reg;
                            lb1_reg <= l_calc;
                        end
                    end
                    if (idx_last) begin
                        state_reg <= ST_MDEC;
                    end else begin
                        idx_reg   <= idx_reg + JW'(1);
                        state_reg <= ST_M0;
                    end
                end

                // apply one move and rescan, or stop
                ST_MDEC: begin
                    idx_reg <= '0;
                    if (mv) begin
                        for (int j = 0; j < JOB_WINDOW; j++) begin
                            if (JW'(j) == to_idx) begin
                                conn_reg[j] <= conn_reg[j] + SLOT_W'(1);
                            end else if (JW'(j) == from_idx) begin
                                conn_reg[j] <= conn_reg[j] - SLOT_W'(1);
                            end
                        end
                        state_reg <= ST_M0;
                    end else begin
                        state_reg <= ST_OLD;
                    end
                end

                ST_OLD: begin
                    m_valid_reg            <= 1'b1;
                    m_data_reg.job_index   <= OUT_IDX_W'(idx_reg);
                    m_data_reg.connections <= k;
                    m_data_reg.last_result <= idx_last;
                    state_reg              <= ST_OUT;
                end

                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (idx_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + JW'(1);
                            state_reg <= ST_OLD;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no new job while a result word is pending
    `UCA_ASSERT_NOW(a_load_vs_result, aclk, aresetn, s_ready, !m_valid_reg, "load while result pending")
    // divider never restarted mid-division
    `UCA_ASSERT_NOW(a_div_free, aclk, aresetn, div_start, !div_stat.busy, "divider restarted while busy")
    // table column never past the slot count
    `UCA_ASSERT_NOW(a_tbl_col, aclk, aresetn, tmem_we, wcol <= slots_reg, "table column out of range")
    // final result returns the block to loading
    `UCA_ASSERT_NEXT(a_back_idle, aclk, aresetn, m_valid && m_ready && m_data.last_result, s_ready, "no return to idle after last result")

endmodule

// ===== src/uca_div.sv =====
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module uca_div
    import uca_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output uca_div_stat_t       stat,
    output logic [NUM_W-1:0]    quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// ===== test/utility_connection_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection allocator testbench
// Feeds windows of jobs through the allocator under several slot settings,
// predicts every job's connection grant from its own utility model and
// compares each result word field by field while both sides idle and stall.
// ----------------------------------------------------------------------------
module utility_connection_allocator_top_tb;
    import uca_pkg::*;

    localparam int WINDOW    = 8;
    localparam int CONN_CAP  = 16;
    localparam int IDLE_WAIT = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    uca_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    uca_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREE_SLOTS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    utility_connection_allocator_top #(
        .JOB_WINDOW      (WINDOW),
        .MAX_CONNECTIONS (CONN_CAP)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Allocation model: configuration, loaded window and pending grants
    // ------------------------------------------------------------------------
    logic [SLOT_W-1:0]  free_slots_m = FREE_SLOTS_RST;
    logic [LIMIT_W-1:0] slot_limit_m = SLOT_LIMIT_RST;
    int                 jobs_loaded = 0;
    longint unsigned    size_m [WINDOW];
    longint unsigned    rate_m [WINDOW];
    longint unsigned    wait_m [WINDOW];
    longint unsigned    dl_m   [WINDOW];
    uca_out_t           grant_q [$];

    int mismatch_count = 0;
    int grants_checked = 0;
    int words_sent     = 0;
    int windows_sent   = 0;

    // estimated response of job j at c connections
    function automatic longint unsigned response_ms(int j, int c);
        longint unsigned den;
        longint unsigned xfer;
        den  = longint'(c) * rate_m[j];
        xfer = (den == 0) ? (64'd1 << 47) : (size_m[j] * slot_limit_m) / den;
        return wait_m[j] + xfer;
    endfunction

    // Q8.8 deadline utility
    function automatic longint unsigned deadline_utility(longint unsigned d,
                                                         longint unsigned r);
        if (r * 20 <= d)
            return 25600;
        if (r * 2 <= d)
            return 26880 - (12800 * r) / d;
        if (r <= d)
            return (40960 * (d - r)) / d;
        return 0;
    endfunction

    // index of best and runner-up; earliest wins ties
    function automatic void rank_two(input longint v[WINDOW], input int n,
                                     input bit want_max, output int f, output int s);
        f = 0;
        s = 0;
        if (n < 2)
            return;
        if (want_max ? (v[0] < v[1]) : (v[0] > v[1])) begin
            f = 1; s = 0;
        end else begin
            f = 0; s = 1;
        end
        for (int i = 2; i < n; i++) begin
            if (want_max ? (v[f] < v[i]) : (v[f] > v[i])) begin
                s = f;
                f = i;
            end else if (want_max ? (v[s] < v[i]) : (v[s] > v[i])) begin
                s = i;
            end
        end
    endfunction

    // share the slots over the loaded window and queue one grant per job
    function automatic void allocate_window();
        longint unsigned tbl [WINDOW][CONN_CAP+1];
        longint          last_r [WINDOW];
        longint          gain [WINDOW];
        longint          loss [WINDOW];
        int              conn [WINDOW];
        int              n, slots, a0, a1, b0, b1, m0, m1, dst, src, o;
        longint          i1, i2;
        bit              moved;
        uca_out_t        g;
        n     = jobs_loaded;
        slots = (free_slots_m > CONN_CAP) ? CONN_CAP : int'(free_slots_m);
        for (int i = 0; i < WINDOW; i++) begin
            conn[i] = 0;
            last_r[i] = 0;
            for (int c = 0; c <= CONN_CAP; c++)
                tbl[i][c] = 0;
        end
        for (int i = 0; i < n; i++) begin
            conn[i] = slots / n + ((i < slots % n) ? 1 : 0);
            for (int c = 1; c <= slots; c++)
                tbl[i][c] = deadline_utility(dl_m[i], response_ms(i, c));
            last_r[i] = longint'(response_ms(i, (slots != 0) ? slots : 1));
        end
        if (n > 1) begin
            rank_two(last_r, n, 1'b0, m0, m1);
            for (int i = 0; i < n; i++) begin
                o = (i != m0) ? m0 : m1;
                tbl[i][0] = deadline_utility(dl_m[i], last_r[i] + last_r[o]);
            end
        end
        for (int guard = 0; guard < 100000; guard++) begin
            for (int i = 0; i < WINDOW; i++) begin
                gain[i] = 0;
                loss[i] = 0;
            end
            for (int i = 0; i < n; i++) begin
                loss[i] = (conn[i] == 0) ? 131071
                        : longint'(tbl[i][conn[i]]) - longint'(tbl[i][conn[i]-1]);
                gain[i] = (conn[i] >= slots) ? -131072
                        : longint'(tbl[i][conn[i]+1]) - longint'(tbl[i][conn[i]]);
            end
            rank_two(gain, n, 1'b1, a0, a1);
            rank_two(loss, n, 1'b0, b0, b1);
            moved = 1'b0;
            dst = 0;
            src = 0;
            if (a0 != b0) begin
                if (gain[a0] - loss[b0] > 0) begin
                    dst = a0; src = b0; moved = 1'b1;
                end
            end else begin
                i1 = gain[a0] - loss[b1];
                i2 = gain[a1] - loss[b0];
                if (i1 >= i2 && i1 > 0) begin
                    dst = a0; src = b1; moved = 1'b1;
                end else if (i2 > i1 && i2 > 0) begin
                    dst = a1; src = b0; moved = 1'b1;
                end
            end
            if (!moved || dst == src)
                break;
            conn[dst]++;
            conn[src]--;
        end
        for (int i = 0; i < n; i++) begin
            g.job_index   = i[OUT_IDX_W-1:0];
            g.connections = conn[i][SLOT_W-1:0];
            g.last_result = (i + 1 == n);
            grant_q.push_back(g);
        end
        jobs_loaded = 0;
    endfunction

    // load one accepted word; only the first WINDOW jobs are kept
    function automatic void load_job(uca_in_t w);
        if (jobs_loaded < WINDOW) begin
            size_m[jobs_loaded] = w.job_size;
            rate_m[jobs_loaded] = w.link_rate;
            wait_m[jobs_loaded] = w.job_wait;
            dl_m[jobs_loaded]   = w.deadline;
            jobs_loaded++;
        end
        if (w.last_job)
            allocate_window();
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted word with the oldest grant
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result word idx=%0d conn=%0d last=%0d",
                             $time, m_data.job_index, m_data.connections,
                             m_data.last_result);
            end else begin
                if (m_data.job_index !== grant_q[0].job_index
                        || m_data.connections !== grant_q[0].connections
                        || m_data.last_result !== grant_q[0].last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: idx/conn/last exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, grant_q[0].job_index, grant_q[0].connections,
                                 grant_q[0].last_result, m_data.job_index,
                                 m_data.connections, m_data.last_result);
                end
                void'(grant_q.pop_front());
                grants_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int hold_seq = 0;
    int hold_len = 0;

    initial begin
        int hold_left;
        int seen_seq;
        int mode;
        int mode_left;
        hold_left = 0;
        seen_seq  = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != seen_seq) begin
                hold_left = hold_len;
                seen_seq  = hold_seq;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 1) == 1);
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // offer one word in bursts with random gaps; advance the model on accept
    task automatic send_job(input uca_in_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        load_job(w);
        words_sent++;
        if (w.last_job)
            windows_sent++;
    endtask

    // drop valid, let every pending grant drain, then let the block settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_FREE_SLOTS)
            free_slots_m = val[SLOT_W-1:0];
        else if (idx == CFG_SLOT_LIMIT)
            slot_limit_m = val[LIMIT_W-1:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_slots(input int free_n, input int limit_n);
        wait_idle();
        write_reg(CFG_FREE_SLOTS, free_n[CFG_DATA_W-1:0]);
        write_reg(CFG_SLOT_LIMIT, limit_n[CFG_DATA_W-1:0]);
    endtask

    function automatic uca_in_t make_job(input logic [SIZE_W-1:0] size,
                                         input logic [RATE_W-1:0] rate,
                                         input logic [WAIT_W-1:0] waited,
                                         input logic [DL_W-1:0] dl,
                                         input bit last);
        uca_in_t w;
        w.job_size  = size;
        w.link_rate = rate;
        w.job_wait  = waited;
        w.deadline  = dl;
        w.last_job  = last;
        return w;
    endfunction

    // mostly jobs whose response sits near the deadline, some raw bit noise
    function automatic uca_in_t random_job(input bit last);
        uca_in_t         w;
        longint unsigned rate;
        rate = $urandom_range(1, 1000);
        if ($urandom_range(0, 4) == 0) begin
            w.job_size  = SIZE_W'({$urandom(), $urandom()});
            w.link_rate = $urandom();
            w.job_wait  = $urandom();
            w.deadline  = $urandom();
        end else begin
            w.job_size  = SIZE_W'(rate * $urandom_range(1, 4000));
            w.link_rate = RATE_W'(rate);
            w.job_wait  = $urandom_range(0, 600);
            w.deadline  = $urandom_range(1, 30000);
        end
        w.last_job = last;
        return w;
    endfunction

    task automatic send_window(input int n);
        for (int i = 0; i < n; i++)
            send_job(random_job(i == n - 1));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_field_extremes();
        // single jobs at the field corners
        send_job(make_job('1, '1, '0, '1, 1'b1));
        send_job(make_job(40'd1, 32'd1, '1, 32'd1, 1'b1));
        // zero deadline met at once, zero deadline missed, zero link rate
        send_job(make_job(40'd1, '1, '0, '0, 1'b0));
        send_job(make_job(40'd5000, 32'd10, 32'd3, '0, 1'b0));
        send_job(make_job(40'd5000, '0, 32'd3, 32'd90000, 1'b0));
        send_job(make_job(40'd800, 32'd20, 32'd1, 32'd400, 1'b1));
    endtask

    task automatic test_config_corners();
        // no free slots: every job gets nothing
        set_slots(0, 16);
        send_job(make_job(40'd1000, 32'd10, 32'd0, 32'd500, 1'b0));
        send_job(make_job(40'd9000, 32'd30, 32'd5, 32'd800, 1'b1));
        // too many free slots get clipped; zero slot limit means no transfer time
        set_slots(31, 0);
        send_job(make_job(40'd1000, 32'd10, 32'd0, 32'd500, 1'b0));
        send_job(make_job(40'd1000, 32'd10, 32'd700, 32'd500, 1'b0));
        send_job(make_job(40'd1000, 32'd10, 32'd20, 32'd500, 1'b1));
        // upper register bits are ignored by the block
        set_slots(8'hE1, 8'hFF);
        send_job(make_job(40'd20000, 32'd7, 32'd2, 32'd60000, 1'b0));
        send_job(make_job(40'd400, 32'd3, 32'd9, 32'd2000, 1'b1));
    endtask

    task automatic test_window_overflow();
        // ten jobs: the last two are dropped but the final one still closes
        set_slots(16, 16);
        for (int i = 0; i < 10; i++)
            send_job(random_job(i == 9));
    endtask

    task automatic test_random_phases();
        int cfg_free  [5] = '{4, 16, 2, 8, 12};
        int cfg_limit [5] = '{64, 16, 1, 20, 100};
        int phase_words;
        int n;
        for (int p = 0; p < 5; p++) begin
            set_slots(cfg_free[p], cfg_limit[p]);
            phase_words = 0;
            while (phase_words < 20) begin
                // keep large windows rare when many slots make them slow
                n = (cfg_free[p] > 8 && $urandom_range(0, 3) != 0)
                    ? $urandom_range(1, 4) : $urandom_range(1, WINDOW);
                send_window(n);
                phase_words += n;
            end
        end
    endtask

    task automatic test_backpressure();
        int n;
        set_slots(6, 32);
        // hold the result side long enough that the input stalls behind it
        hold_len = 3000;
        hold_seq++;
        for (int k = 0; k < 3; k++) begin
            n = $urandom_range(2, WINDOW);
            send_window(n);
        end
        // sender pause: every grant drains before the next window
        wait_idle();
        send_window(3);
        wait_idle();
        send_window(WINDOW);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_field_extremes();
        test_config_corners();
        test_window_overflow();
        test_random_phases();
        test_backpressure();

        wait_idle();
        $display("Sent %0d job words in %0d windows under the reset and ten written slot settings;",
                 words_sent, windows_sent);
        $display("checked %0d connection grants, %0d mismatching.",
                 grants_checked, mismatch_count);
        if (mismatch_count == 0 && grant_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("Timeout with %0d grants outstanding", grant_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
